>>> rtl/blr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types, constants and helper function of the Benes looping router.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int PORT_CAP      = 16;
    localparam int MAX_PORTS_DEF = 16;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_UP   = 2'd1;
    localparam logic [1:0] MARK_LOW  = 2'd2;

    localparam logic       CFG_SIZE_LOG2    = 1'b0;
    localparam logic       CFG_ROUTE_LEVELS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_PCLR,
        ST_PSTEP,
        ST_EMIT,
        ST_SORT,
        ST_PART,
        ST_ASGN,
        ST_GATH,
        ST_WBACK,
        ST_ASC
    } state_t;

    function automatic logic [1:0] mark_left(input logic [1:0] nb, input logic [1:0] partner);
        logic [1:0] r;
        if (nb == MARK_UP)
        begin
            r = MARK_LOW;
        end
        else if (nb == MARK_LOW)
        begin
            r = MARK_UP;
        end
        else
        begin
            r = (partner == MARK_LOW) ? MARK_LOW : MARK_UP;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/benes_looping_router_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// benes_looping_router_core
// Loads a permutation and routes a Benes network with the looping algorithm.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) loads one right port per beat:
//   entry_index, dest_value; a beat with last_entry set starts routing.
//   Routing runs a small sequencer over the subnetworks depth first; per
//   subnetwork of m ports it has a clear step, up to 4m+4 walk steps (one
//   per cycle), m/2 result beats and, when it splits, sort, lookup and
//   relabel passes. The input is not ready while routing. Results
//   (out_valid/out_ready) leave through an output register; a stalled
//   receiver holds the sequencer in its emit step. last_result marks the
//   final beat of a run.
//   Config writes (cfg_we, cfg_index, cfg_data) take effect at once and must
//   be made only while idle; the block itself does not enforce this.
//   Reset: size_log2 4, route_levels 3, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module benes_looping_router_core
    import blr_pkg::*;
#(
    parameter int MAX_PORTS = MAX_PORTS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [2:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [3:0] entry_index,
    input  wire logic [3:0] dest_value,
    input  wire logic       last_entry,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      level,
    output logic [2:0]      sub_index,
    output logic [2:0]      switch_index,
    output logic            first_cross,
    output logic            last_cross,
    output logic            pair_error,
    output logic            last_result
);

    localparam int FLOOR_LOG2 = $clog2(MAX_PORTS + 1) - 1;
    localparam int SIZE_CAP   = (FLOOR_LOG2 < 4) ? FLOOR_LOG2 : 4;

    logic [3:0] rv [PORT_CAP];
    logic [3:0] lv [PORT_CAP];
    logic [3:0] wr [PORT_CAP];
    logic [1:0] lm [PORT_CAP];
    logic [1:0] rm [PORT_CAP];
    logic [3:0] ord_l [PORT_CAP];
    logic [3:0] ord_r [PORT_CAP];
    logic [3:0] partner [PORT_CAP];
    logic [3:0] tmp [PORT_CAP];

    state_t     state_reg, state_next;
    logic [2:0] size_log2_reg;
    logic [1:0] route_levels_reg;
    logic [1:0] lvl_reg, lvl_next;
    logic [2:0] sub_reg, sub_next;
    logic [3:0] i_reg, i_next;
    logic [6:0] guard_reg, guard_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] c_reg, c_next;
    logic [4:0] pl_reg, pl_next;
    logic [4:0] pr_reg, pr_next;
    logic       out_valid_reg;
    logic [1:0] o_level_reg;
    logic [2:0] o_sub_reg, o_sw_reg;
    logic       o_fc_reg, o_lc_reg, o_err_reg, o_last_reg;

    logic [2:0] s_eff;
    logic [1:0] lvc;
    logic [2:0] shamt;
    logic [4:0] m;
    logic [3:0] b, mask, half_mask, m_last;
    logic [2:0] k_end;
    logic [6:0] limit;
    logic       accept, fire, is_last_node, emit_end, sort_end, pass_end;
    logic       hit_l, hit_r;
    logic [1:0] tl [PORT_CAP];
    logic [1:0] tr [PORT_CAP];
    logic [3:0] step_i;
    logic       step_done, found, all_set;
    logic [3:0] ksel, ai, aj, arnb, ai2, i2;
    logic [3:0] e0, e1;
    logic [1:0] le, lo, re, ro;

    function automatic logic [3:0] find_right(input logic [3:0] w [PORT_CAP],
                                              input logic [3:0] base,
                                              input logic [4:0] size,
                                              input logic [3:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int k = PORT_CAP - 1; k >= 0; k--)
        begin
            if (5'(k) < size && w[base + 4'(k)] == v)
            begin
                r = 4'(k);
            end
        end
        return r;
    endfunction

    function automatic logic sort_hit(input logic [1:0] c, input logic [1:0] mk);
        logic h;
        case (c)
            2'd0:    h = (mk == MARK_UP);
            2'd1:    h = (mk == MARK_LOW);
            default: h = (mk != MARK_UP) && (mk != MARK_LOW);
        endcase
        return h;
    endfunction

    // ---- derived node geometry
    always_comb
    begin
        if (size_log2_reg < 3'd1)
        begin
            s_eff = 3'd1;
        end
        else if (size_log2_reg > 3'(SIZE_CAP))
        begin
            s_eff = 3'(SIZE_CAP);
        end
        else
        begin
            s_eff = size_log2_reg;
        end
        lvc       = ({1'b0, route_levels_reg} > s_eff - 3'd1) ? 2'(s_eff - 3'd1)
                                                               : route_levels_reg;
        shamt     = s_eff - {1'b0, lvl_reg};
        m         = 5'(6'd1 << shamt);
        b         = 4'({5'd0, sub_reg} << shamt);
        mask      = 4'(m - 5'd1);
        half_mask = 4'((m >> 1) - 5'd1);
        m_last    = mask;
        k_end     = 3'((m >> 1) - 5'd1);
        limit     = {m, 2'b00} + 7'd4;
    end

    assign accept       = in_valid && in_ready;
    assign in_ready     = (state_reg == ST_IDLE);
    assign fire         = !out_valid_reg || out_ready;
    assign is_last_node = (lvl_reg == lvc) && (sub_reg == 3'((4'd1 << lvc) - 4'd1));
    assign emit_end     = (k_reg[2:0] == k_end);
    assign sort_end     = (c_reg == 2'd2) && (k_reg == m_last);
    assign pass_end     = (k_reg == m_last);
    assign hit_l        = sort_hit(c_reg, lm[b + k_reg]);
    assign hit_r        = sort_hit(c_reg, rm[b + k_reg]);

    // ---- one walk step of the looping pass
    always_comb
    begin
        tl        = lm;
        tr        = rm;
        step_i    = i_reg;
        step_done = 1'b0;
        found     = 1'b0;
        all_set   = 1'b1;
        ksel      = 4'd0;
        ai        = b + i_reg;
        aj        = 4'd0;
        arnb      = 4'd0;
        i2        = 4'd0;
        ai2       = 4'd0;
        if (lm[ai] != MARK_NONE)
        begin
            for (int k = 0; k < PORT_CAP; k++)
            begin
                if (5'(k) < m && lm[b + 4'(k)] == MARK_NONE)
                begin
                    found = 1'b1;
                    ksel  = 4'(k);
                end
            end
            step_i    = ksel;
            step_done = !found;
        end
        else
        begin
            aj     = b + find_right(wr, b, m, lv[ai]);
            arnb   = b + ((aj - b) ^ 4'd1);
            tl[ai] = mark_left(tl[b + (i_reg ^ 4'd1)], tr[aj]);
            if (tr[aj] == MARK_NONE)
            begin
                if (tr[arnb] == MARK_UP)
                begin
                    tr[aj] = MARK_LOW;
                end
                else if (tr[arnb] == MARK_LOW)
                begin
                    tr[aj] = MARK_UP;
                end
                else if (tl[ai] == MARK_LOW)
                begin
                    tr[aj]   = MARK_LOW;
                    tr[arnb] = MARK_UP;
                end
                else
                begin
                    tr[aj]   = MARK_UP;
                    tr[arnb] = MARK_LOW;
                end
            end
            i2  = wr[arnb] & mask;
            ai2 = b + i2;
            if (tl[ai2] == MARK_NONE)
            begin
                tl[ai2] = mark_left(tl[b + (i2 ^ 4'd1)], tr[arnb]);
            end
            step_i = i2 ^ 4'd1;
            for (int k = 0; k < PORT_CAP; k++)
            begin
                if (5'(k) < m && tr[b + 4'(k)] == MARK_NONE)
                begin
                    all_set = 1'b0;
                end
            end
            step_done = all_set;
        end
    end

    // ---- emit view of one switch pair
    always_comb
    begin
        e0 = b + {k_reg[2:0], 1'b0};
        e1 = b + {k_reg[2:0], 1'b1};
        le = lm[e0];
        lo = lm[e1];
        re = rm[e0];
        ro = rm[e1];
    end

    // ---- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_entry)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_PCLR;
            ST_PCLR:  state_next = ST_PSTEP;
            ST_PSTEP:
            begin
                if (guard_reg == limit || step_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (fire && emit_end)
                begin
                    state_next = (lvl_reg < lvc) ? ST_SORT : ST_ASC;
                end
            end
            ST_SORT:  state_next = sort_end ? ST_PART : ST_SORT;
            ST_PART:  state_next = pass_end ? ST_ASGN : ST_PART;
            ST_ASGN:  state_next = pass_end ? ST_GATH : ST_ASGN;
            ST_GATH:  state_next = pass_end ? ST_WBACK : ST_GATH;
            ST_WBACK: state_next = pass_end ? ST_PCLR : ST_WBACK;
            ST_ASC:
            begin
                if (lvl_reg == 2'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sub_reg[0])
                begin
                    state_next = ST_PCLR;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---- sequencer counters
    always_comb
    begin
        lvl_next   = lvl_reg;
        sub_next   = sub_reg;
        i_next     = i_reg;
        guard_next = guard_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        pl_next    = pl_reg;
        pr_next    = pr_reg;
        case (state_reg)
            ST_INIT:
            begin
                lvl_next = 2'd0;
                sub_next = 3'd0;
            end
            ST_PCLR:
            begin
                i_next     = 4'd0;
                guard_next = 7'd0;
            end
            ST_PSTEP:
            begin
                i_next     = step_i;
                guard_next = guard_reg + 7'd1;
                k_next     = 4'd0;
            end
            ST_EMIT:
            begin
                if (fire)
                begin
                    k_next = emit_end ? 4'd0 : k_reg + 4'd1;
                end
                c_next  = 2'd0;
                pl_next = 5'd0;
                pr_next = 5'd0;
            end
            ST_SORT:
            begin
                pl_next = pl_reg + 5'(hit_l);
                pr_next = pr_reg + 5'(hit_r);
                if (k_reg == m_last)
                begin
                    k_next = 4'd0;
                    c_next = c_reg + 2'd1;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
            ST_PART, ST_ASGN, ST_GATH:
            begin
                k_next = pass_end ? 4'd0 : k_reg + 4'd1;
            end
            ST_WBACK:
            begin
                k_next = pass_end ? 4'd0 : k_reg + 4'd1;
                if (pass_end)
                begin
                    lvl_next = lvl_reg + 2'd1;
                    sub_next = {sub_reg[1:0], 1'b0};
                end
            end
            ST_ASC:
            begin
                if (lvl_reg != 2'd0)
                begin
                    if (sub_reg[0])
                    begin
                        lvl_next = lvl_reg - 2'd1;
                        sub_next = {1'b0, sub_reg[2:1]};
                    end
                    else
                    begin
                        sub_next = sub_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            size_log2_reg    <= 3'd4;
            route_levels_reg <= 2'd3;
            lvl_reg          <= 2'd0;
            sub_reg          <= 3'd0;
            i_reg            <= 4'd0;
            guard_reg        <= 7'd0;
            k_reg            <= 4'd0;
            c_reg            <= 2'd0;
            pl_reg           <= 5'd0;
            pr_reg           <= 5'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            sub_reg   <= sub_next;
            i_reg     <= i_next;
            guard_reg <= guard_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            pl_reg    <= pl_next;
            pr_reg    <= pr_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_SIZE_LOG2)
                begin
                    size_log2_reg <= cfg_data;
                end
                else
                begin
                    route_levels_reg <= cfg_data[1:0];
                end
            end
            if (state_reg == ST_EMIT && fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- result register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && fire)
        begin
            o_level_reg <= lvl_reg;
            o_sub_reg   <= sub_reg;
            o_sw_reg    <= k_reg[2:0];
            o_fc_reg    <= (le == MARK_LOW) && (lo == MARK_UP);
            o_lc_reg    <= (re == MARK_LOW) && (ro == MARK_UP);
            o_err_reg   <= !((((le == MARK_UP) && (lo == MARK_LOW)) ||
                              ((le == MARK_LOW) && (lo == MARK_UP))) &&
                             (((re == MARK_UP) && (ro == MARK_LOW)) ||
                              ((re == MARK_LOW) && (ro == MARK_UP))));
            o_last_reg  <= is_last_node && emit_end;
        end
    end

    // ---- storage
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ({1'b0, entry_index} < m))
                begin
                    rv[entry_index] <= dest_value;
                end
            end
            ST_INIT:
            begin
                for (int k = 0; k < PORT_CAP; k++)
                begin
                    lv[k] <= 4'(k);
                    wr[k] <= rv[k];
                end
            end
            ST_PCLR:
            begin
                for (int k = 0; k < PORT_CAP; k++)
                begin
                    if (4'(k) - b < m[3:0] || (m[4] && 4'(k) >= b))
                    begin
                        lm[k] <= MARK_NONE;
                        rm[k] <= MARK_NONE;
                    end
                end
            end
            ST_PSTEP:
            begin
                if (guard_reg != limit)
                begin
                    lm <= tl;
                    rm <= tr;
                end
            end
            ST_SORT:
            begin
                if (hit_l)
                begin
                    ord_l[pl_reg[3:0]] <= k_reg;
                end
                if (hit_r)
                begin
                    ord_r[pr_reg[3:0]] <= k_reg;
                end
            end
            ST_PART:
            begin
                partner[k_reg] <= find_right(wr, b, m, lv[b + ord_l[k_reg]]);
            end
            ST_ASGN:
            begin
                wr[b + partner[k_reg]] <= k_reg & half_mask;
            end
            ST_GATH:
            begin
                tmp[k_reg] <= wr[b + ord_r[k_reg]];
            end
            ST_WBACK:
            begin
                wr[b + k_reg] <= tmp[k_reg];
                lv[b + k_reg] <= k_reg & half_mask;
            end
            default:
            begin
                tmp[0] <= tmp[0];
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign level        = o_level_reg;
    assign sub_index    = o_sub_reg;
    assign switch_index = o_sw_reg;
    assign first_cross  = o_fc_reg;
    assign last_cross   = o_lc_reg;
    assign pair_error   = o_err_reg;
    assign last_result  = o_last_reg;

endmodule
`default_nettype wire
